>>> src/peer_reconnect_backoff_scheduler_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the reconnect backoff scheduler
// Shared concurrent check forms, clocked and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PEER_RECONNECT_BACKOFF_SCHEDULER_DEFINES_SVH
`define PEER_RECONNECT_BACKOFF_SCHEDULER_DEFINES_SVH

// same-cycle implication
`define PRB_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("prb: same-cycle check failed");

// next-cycle implication
`define PRB_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("prb: next-cycle check failed");

`endif

>>> src/prb_pkg.sv
// ----------------------------------------------------------------------------
// prb_pkg
// Types, codes and backoff table of the reconnect backoff scheduler.
// ----------------------------------------------------------------------------
package prb_pkg;

  localparam logic [2:0] ACT_USER_DISCONNECT = 3'd0;
  localparam logic [2:0] ACT_LINK_LOST       = 3'd1;
  localparam logic [2:0] ACT_LINK_UP         = 3'd2;
  localparam logic [2:0] ACT_RESEEK          = 3'd3;
  localparam logic [2:0] ACT_TICK            = 3'd4;

  localparam logic [7:0] ATTEMPT_CAP = 8'd250;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [2:0]  action;
    logic [1:0]  peer;
    logic [31:0] now_ms;
    logic        auto_reconnect;
    logic        has_saved_address;
    logic        eligible;
    logic        connected;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  peer_echo;
    logic        kick_connect;
    logic [7:0]  attempt_count;
    logic        pending;
    logic [31:0] next_due_ms;
  } result_t;

  typedef enum logic [2:0] {
    OP_USER_DISCONNECT,
    OP_LINK_LOST,
    OP_LINK_UP,
    OP_RESEEK,
    OP_TICK,
    OP_NOP,
    OP_OUT_OF_RANGE
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [1:0]  peer;
    logic [31:0] now_ms;
    logic        auto_reconnect;
    logic        has_saved_address;
    logic        eligible;
    logic        connected;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  function automatic logic [31:0] backoff_ms(input logic [7:0] n);
    logic [31:0] ms;
    case (n)
      8'd0:    ms = 32'd5000;
      8'd1:    ms = 32'd15000;
      8'd2:    ms = 32'd45000;
      8'd3:    ms = 32'd90000;
      default: ms = 32'd180000;
    endcase
    return ms;
  endfunction

endpackage

>>> src/prb_front.sv
// ----------------------------------------------------------------------------
// prb_front
// Accepts items, classifies event code and peer range, pushes to the queue.
// ----------------------------------------------------------------------------
module prb_front #(
  parameter int PEERS = 4
) (
  input  logic                   start,
  input  prb_pkg::cmd_t          cmd,
  input  prb_pkg::queue_status_t qstat,
  output logic                   busy,
  output logic                   push,
  output prb_pkg::entry_t        entry
);

  prb_pkg::op_e op;

  always_comb begin
    unique case (cmd.action)
      prb_pkg::ACT_USER_DISCONNECT: op = prb_pkg::OP_USER_DISCONNECT;
      prb_pkg::ACT_LINK_LOST:       op = prb_pkg::OP_LINK_LOST;
      prb_pkg::ACT_LINK_UP:         op = prb_pkg::OP_LINK_UP;
      prb_pkg::ACT_RESEEK:          op = prb_pkg::OP_RESEEK;
      prb_pkg::ACT_TICK:            op = prb_pkg::OP_TICK;
      default:                      op = prb_pkg::OP_NOP;
    endcase
    if (32'(cmd.peer) >= PEERS) begin
      op = prb_pkg::OP_OUT_OF_RANGE;
    end
  end

  assign busy = qstat.full;
  assign push = start && !qstat.full;

  always_comb begin
    entry.op                = op;
    entry.peer              = cmd.peer;
    entry.now_ms            = cmd.now_ms;
    entry.auto_reconnect    = cmd.auto_reconnect;
    entry.has_saved_address = cmd.has_saved_address;
    entry.eligible          = cmd.eligible;
    entry.connected         = cmd.connected;
  end

endmodule

>>> src/prb_queue.sv
// ----------------------------------------------------------------------------
// prb_queue
// Short FIFO between the classifying front and the executing back.
// ----------------------------------------------------------------------------
module prb_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  prb_pkg::entry_t        push_data,
  input  logic                   pop,
  output prb_pkg::entry_t        head,
  output prb_pkg::queue_status_t qstat
);

  prb_pkg::entry_t slots [prb_pkg::QUEUE_DEPTH];
  logic [prb_pkg::QPTR_W-1:0] wr_ptr;
  logic [prb_pkg::QPTR_W-1:0] rd_ptr;
  logic [prb_pkg::QCNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  assign head        = slots[rd_ptr];
  assign qstat.full  = (count == prb_pkg::QCNT_W'(prb_pkg::QUEUE_DEPTH));
  assign qstat.empty = (count == '0);

endmodule

>>> src/prb_back.sv
// ----------------------------------------------------------------------------
// prb_back
// Per-peer state update and result register; one queued item per cycle.
// ----------------------------------------------------------------------------
`include "peer_reconnect_backoff_scheduler_defines.svh"

module prb_back #(
  parameter int PEERS = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  prb_pkg::queue_status_t qstat,
  input  prb_pkg::entry_t        head,
  output logic                   pop,
  output logic                   done,
  output prb_pkg::result_t       result
);

  localparam int PIDX_W = (PEERS > 1) ? $clog2(PEERS) : 1;

  logic        user_suppressed [PEERS];
  logic        want_reconnect  [PEERS];
  logic        forced_once     [PEERS];
  logic [7:0]  attempts        [PEERS];
  logic [31:0] due_time        [PEERS];

  logic             in_range;
  logic [PIDX_W-1:0] idx;

  logic        cur_supp, cur_want, cur_forced;
  logic [7:0]  cur_att;
  logic [31:0] cur_due;

  logic        supp_next, want_next, forced_next;
  logic [7:0]  att_next;
  logic [31:0] due_next;
  logic        kick;
  logic [7:0]  att_inc;
  logic [31:0] elapsed;

  assign pop      = !qstat.empty;
  assign in_range = (head.op != prb_pkg::OP_OUT_OF_RANGE);
  assign idx      = in_range ? PIDX_W'(head.peer) : '0;

  assign cur_supp   = user_suppressed[idx];
  assign cur_want   = want_reconnect[idx];
  assign cur_forced = forced_once[idx];
  assign cur_att    = attempts[idx];
  assign cur_due    = due_time[idx];

  assign att_inc = (cur_att < prb_pkg::ATTEMPT_CAP) ? cur_att + 8'd1 : cur_att;
  assign elapsed = head.now_ms - cur_due;

  always_comb begin
    supp_next   = cur_supp;
    want_next   = cur_want;
    forced_next = cur_forced;
    att_next    = cur_att;
    due_next    = cur_due;
    kick        = 1'b0;
    unique case (head.op)
      prb_pkg::OP_USER_DISCONNECT: begin
        supp_next   = 1'b1;
        want_next   = 1'b0;
        forced_next = 1'b0;
        att_next    = '0;
        due_next    = '0;
      end
      prb_pkg::OP_LINK_LOST: begin
        if (!cur_supp && head.auto_reconnect && head.has_saved_address &&
            head.eligible) begin
          want_next = 1'b1;
          if (cur_due == '0) begin
            att_next = '0;
            due_next = head.now_ms + prb_pkg::backoff_ms(8'd0);
          end
        end
      end
      prb_pkg::OP_LINK_UP: begin
        supp_next   = 1'b0;
        want_next   = 1'b0;
        forced_next = 1'b0;
        att_next    = '0;
        due_next    = '0;
      end
      prb_pkg::OP_RESEEK: begin
        if (!cur_supp && head.has_saved_address && head.eligible &&
            !head.connected) begin
          want_next   = 1'b1;
          forced_next = 1'b1;
          att_next    = '0;
          due_next    = head.now_ms;
        end
      end
      prb_pkg::OP_TICK: begin
        if (head.eligible && cur_want) begin
          if (cur_supp || !(head.auto_reconnect || cur_forced) ||
              !head.has_saved_address) begin
            want_next   = 1'b0;
            forced_next = 1'b0;
          end else if (head.connected) begin
            supp_next   = 1'b0;
            want_next   = 1'b0;
            forced_next = 1'b0;
            att_next    = '0;
            due_next    = '0;
          end else if (cur_due == '0 || !elapsed[31]) begin
            kick     = 1'b1;
            att_next = att_inc;
            if (!head.auto_reconnect && cur_forced) begin
              want_next   = 1'b0;
              forced_next = 1'b0;
              due_next    = '0;
            end else begin
              due_next = head.now_ms + prb_pkg::backoff_ms(att_inc);
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PEERS; i++) begin
        user_suppressed[i] <= 1'b0;
        want_reconnect[i]  <= 1'b0;
        forced_once[i]     <= 1'b0;
        attempts[i]        <= '0;
        due_time[i]        <= '0;
      end
      done <= 1'b0;
    end else begin
      done <= pop;
      if (pop && in_range) begin
        user_suppressed[idx] <= supp_next;
        want_reconnect[idx]  <= want_next;
        forced_once[idx]     <= forced_next;
        attempts[idx]        <= att_next;
        due_time[idx]        <= due_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result.peer_echo     <= head.peer;
      result.kick_connect  <= in_range && kick;
      result.attempt_count <= in_range ? att_next : '0;
      result.pending       <= in_range && want_next;
      result.next_due_ms   <= in_range ? due_next : '0;
    end
  end

  `PRB_ASSERT_NXT(a_pop_gives_done, clk, rst, pop, done)
  `PRB_ASSERT_IMP(a_kick_counts, clk, rst, done && result.kick_connect, result.attempt_count != 8'd0)
  `PRB_ASSERT_IMP(a_out_of_range_zero, clk, rst, done && (32'(result.peer_echo) >= PEERS), !result.kick_connect && !result.pending && result.attempt_count == 8'd0 && result.next_due_ms == 32'd0)

endmodule

>>> src/peer_reconnect_backoff_scheduler.sv
// ----------------------------------------------------------------------------
// peer_reconnect_backoff_scheduler
// Per-peer reconnect scheduler with exponential backoff.
// ----------------------------------------------------------------------------
// Use: drive cmd and raise start; the item is taken at a rising edge where
// start is high and busy is low. Each item names a peer, an event and the
// millisecond time, plus that peer's flags.
// Every item yields one result on the result port, marked by done for one
// cycle. The front classifies the item and writes it into the queue; the
// back reads the peer's state, updates it and registers the result and
// done.
// One item per cycle is sustained: the back retires one queued item each
// cycle, so the two-entry queue does not fill and busy stays low.
// Results cannot be stalled by the receiver; they must be taken when shown.
// Reset (rst, synchronous) empties the queue and clears all per-peer state:
// no peer suppressed or pending, zero attempts, no due time.
// Peer index >= PEERS: state is left alone, result zero but for peer_echo.
// ----------------------------------------------------------------------------
module peer_reconnect_backoff_scheduler #(
  parameter int PEERS = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  prb_pkg::cmd_t    cmd,
  output logic             busy,
  output logic             done,
  output prb_pkg::result_t result
);

  prb_pkg::queue_status_t qstat;
  prb_pkg::entry_t        push_data;
  prb_pkg::entry_t        head;
  logic                   push;
  logic                   pop;

  prb_front #(
    .PEERS(PEERS)
  ) u_front (
    .start (start),
    .cmd   (cmd),
    .qstat (qstat),
    .busy  (busy),
    .push  (push),
    .entry (push_data)
  );

  prb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .qstat     (qstat)
  );

  prb_back #(
    .PEERS(PEERS)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .qstat  (qstat),
    .head   (head),
    .pop    (pop),
    .done   (done),
    .result (result)
  );

endmodule

>>> bench/peer_reconnect_backoff_scheduler_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// peer_reconnect_backoff_scheduler_test
// Self-checking bench for the per-peer reconnect backoff scheduler. A short
// table of events covers the extremes of the fields, every event, unused event
// codes, wrapped due times and one-shot reseeks. Random events on four peers
// follow, plus a long tick run on one peer that drives its attempt count into
// saturation. Each result is checked against its table row or an internal model.
// ----------------------------------------------------------------------------
module peer_reconnect_backoff_scheduler_test;

  localparam int PEERS            = 4;
  localparam int RANDOM_ITEMS     = 480;
  localparam int SATURATION_TICKS = 260;
  localparam int IDLE_LIMIT       = 1000;

  localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
  localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;

  typedef struct {
    prb_pkg::cmd_t    c;
    bit               has_exp;
    prb_pkg::result_t exp;
  } stim_row_t;

  logic             clk = 1'b0;
  logic             rst;
  logic             start;
  prb_pkg::cmd_t    cmd;
  logic             busy;
  logic             done;
  prb_pkg::result_t result;

  logic       peer_suppressed [PEERS];
  logic       peer_wanted     [PEERS];
  logic       peer_forced     [PEERS];
  logic [7:0] peer_tries      [PEERS];
  logic [31:0] peer_due       [PEERS];

  prb_pkg::result_t expected_q [$];
  stim_row_t        stim_table [$];
  bit               row_has_exp;
  prb_pkg::result_t row_exp;
  logic [31:0]      clock_ms;

  int         fails;
  int         items_accepted;
  int         kicks_seen;
  logic [7:0] top_tries;
  int         idle_cycles;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  peer_reconnect_backoff_scheduler #(.PEERS(PEERS)) DUT (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done),
    .result(result)
  );

  function automatic logic [31:0] retry_delay(input logic [7:0] n);
    logic [31:0] ms;
    case (n)
      8'd0:    ms = 32'd5000;
      8'd1:    ms = 32'd15000;
      8'd2:    ms = 32'd45000;
      8'd3:    ms = 32'd90000;
      default: ms = 32'd180000;
    endcase
    return ms;
  endfunction

  task automatic clear_peer(input logic [1:0] p);
    peer_suppressed[p] = 1'b0;
    peer_wanted[p]     = 1'b0;
    peer_forced[p]     = 1'b0;
    peer_tries[p]      = 8'd0;
    peer_due[p]        = 32'd0;
  endtask

  task automatic predict_schedule(input prb_pkg::cmd_t c, output prb_pkg::result_t r);
    logic [1:0]  p;
    logic        kick;
    logic [31:0] lag;
    p    = c.peer;
    kick = 1'b0;
    lag  = c.now_ms - peer_due[p];
    case (c.action)
      prb_pkg::ACT_USER_DISCONNECT: begin
        clear_peer(p);
        peer_suppressed[p] = 1'b1;
      end
      prb_pkg::ACT_LINK_LOST: begin
        if (!peer_suppressed[p] && c.auto_reconnect && c.has_saved_address &&
            c.eligible) begin
          peer_wanted[p] = 1'b1;
          if (peer_due[p] == 32'd0) begin
            peer_tries[p] = 8'd0;
            peer_due[p]   = c.now_ms + retry_delay(8'd0);
          end
        end
      end
      prb_pkg::ACT_LINK_UP: clear_peer(p);
      prb_pkg::ACT_RESEEK: begin
        if (!peer_suppressed[p] && c.has_saved_address && c.eligible &&
            !c.connected) begin
          peer_wanted[p] = 1'b1;
          peer_forced[p] = 1'b1;
          peer_tries[p]  = 8'd0;
          peer_due[p]    = c.now_ms;
        end
      end
      prb_pkg::ACT_TICK: begin
        if (c.eligible && peer_wanted[p]) begin
          if (peer_suppressed[p] || !(c.auto_reconnect || peer_forced[p]) ||
              !c.has_saved_address) begin
            peer_wanted[p] = 1'b0;
            peer_forced[p] = 1'b0;
          end else if (c.connected) begin
            clear_peer(p);
          end else if (peer_due[p] == 32'd0 || !lag[31]) begin
            kick = 1'b1;
            if (peer_tries[p] < prb_pkg::ATTEMPT_CAP) peer_tries[p] = peer_tries[p] + 8'd1;
            if (!c.auto_reconnect && peer_forced[p]) begin
              peer_wanted[p] = 1'b0;
              peer_forced[p] = 1'b0;
              peer_due[p]    = 32'd0;
            end else begin
              peer_due[p] = c.now_ms + retry_delay(peer_tries[p]);
            end
          end
        end
      end
      default: ;
    endcase
    r.peer_echo     = p;
    r.kick_connect  = kick;
    r.attempt_count = peer_tries[p];
    r.pending       = peer_wanted[p];
    r.next_due_ms   = peer_due[p];
  endtask

  function automatic void add_row(input logic [2:0] act, input logic [1:0] p,
                                  input logic [31:0] now, input logic [3:0] flags,
                                  input bit chk, input logic kick, input logic [7:0] tries,
                                  input logic pend, input logic [31:0] due);
    stim_row_t row;
    row.c.action            = act;
    row.c.peer              = p;
    row.c.now_ms            = now;
    row.c.auto_reconnect    = flags[3];
    row.c.has_saved_address = flags[2];
    row.c.eligible          = flags[1];
    row.c.connected         = flags[0];
    row.has_exp             = chk;
    row.exp.peer_echo       = p;
    row.exp.kick_connect    = kick;
    row.exp.attempt_count   = tries;
    row.exp.pending         = pend;
    row.exp.next_due_ms     = due;
    stim_table.push_back(row);
  endfunction

  function automatic prb_pkg::cmd_t random_cmd();
    prb_pkg::cmd_t c;
    int            pick;
    pick = $urandom_range(0, 99);
    if (pick < 45)      c.action = prb_pkg::ACT_TICK;
    else if (pick < 63) c.action = prb_pkg::ACT_LINK_LOST;
    else if (pick < 75) c.action = prb_pkg::ACT_RESEEK;
    else if (pick < 85) c.action = prb_pkg::ACT_LINK_UP;
    else if (pick < 91) c.action = prb_pkg::ACT_USER_DISCONNECT;
    else                c.action = 3'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
    case ($urandom_range(0, 9))
      0:       clock_ms = $urandom;
      1:       clock_ms = 32'hFFFF_0000 + 32'($urandom_range(0, 65535));
      default: clock_ms = clock_ms + 32'($urandom_range(0, 200000));
    endcase
    c.peer              = 2'($urandom_range(0, PEERS - 1));
    c.now_ms            = clock_ms;
    c.auto_reconnect    = $urandom_range(0, 99) < 85;
    c.has_saved_address = $urandom_range(0, 99) < 90;
    c.eligible          = $urandom_range(0, 99) < 90;
    c.connected         = $urandom_range(0, 99) < 15;
    return c;
  endfunction

  // hold the item until the block takes it
  task automatic send_item(input prb_pkg::cmd_t c, input bit has_exp,
                           input prb_pkg::result_t exp, input int gap);
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start       <= 1'b1;
    cmd         <= c;
    row_has_exp <= has_exp;
    row_exp     <= exp;
    do @(posedge clk); while (busy);
  endtask

  always @(posedge clk) begin
    prb_pkg::result_t predicted;
    prb_pkg::result_t want;
    if (!rst) begin
      if (start && !busy) begin
        predict_schedule(cmd, predicted);
        expected_q.push_back(row_has_exp ? row_exp : predicted);
        items_accepted++;
      end
      if (done) begin
        if (result.kick_connect) kicks_seen++;
        if (result.attempt_count > top_tries) top_tries = result.attempt_count;
        if (expected_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected result, expected none, actual %p", $time, result);
        end else begin
          want = expected_q.pop_front();
          if (result !== want) begin
            fails++;
            $display({"%0t: mismatch peer %0d/%0d kick %0d/%0d attempts %0d/%0d ",
                      "pending %0d/%0d due %0d/%0d (expected/actual)"},
                     $time, want.peer_echo, result.peer_echo,
                     want.kick_connect, result.kick_connect,
                     want.attempt_count, result.attempt_count,
                     want.pending, result.pending,
                     want.next_due_ms, result.next_due_ms);
          end
        end
      end
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || done) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    prb_pkg::cmd_t    c;
    prb_pkg::result_t none;
    bit               no_gaps;
    logic [1:0]       sat_peer;
    rst         = 1'b1;
    start       = 1'b0;
    cmd         = '0;
    row_has_exp = 1'b0;
    row_exp     = '0;
    none        = '0;
    fails       = 0;
    items_accepted = 0;
    kicks_seen  = 0;
    top_tries   = 8'd0;
    for (int i = 0; i < PEERS; i++) clear_peer(2'(i));

    add_row(prb_pkg::ACT_TICK,      2'd0, 32'd0,         4'b1110, 1, 0, 0, 0, 32'd0);
    add_row(prb_pkg::ACT_LINK_LOST, 2'd0, 32'hFFFF_FFFF, 4'b1110, 1, 0, 0, 1, 32'd4999);
    add_row(prb_pkg::ACT_TICK,      2'd0, 32'd0,         4'b1110, 1, 0, 0, 1, 32'd4999);
    add_row(prb_pkg::ACT_TICK,      2'd0, 32'd4999,      4'b1110, 1, 1, 1, 1, 32'd19999);
    add_row(prb_pkg::ACT_TICK,      2'd0, 32'd30000,     4'b1100, 1, 0, 1, 1, 32'd19999);
    add_row(ACT_SPARE_FIRST,        2'd0, 32'd30000,     4'b1111, 1, 0, 1, 1, 32'd19999);
    add_row(ACT_SPARE_LAST,         2'd1, 32'd0,         4'b0000, 1, 0, 0, 0, 32'd0);
    add_row(prb_pkg::ACT_USER_DISCONNECT, 2'd0, 32'd31000, 4'b1110, 1, 0, 0, 0, 32'd0);
    add_row(prb_pkg::ACT_LINK_LOST, 2'd0, 32'd32000,     4'b1110, 1, 0, 0, 0, 32'd0);
    add_row(prb_pkg::ACT_RESEEK,    2'd0, 32'd33000,     4'b1110, 1, 0, 0, 0, 32'd0);
    add_row(prb_pkg::ACT_LINK_UP,   2'd0, 32'd34000,     4'b0000, 1, 0, 0, 0, 32'd0);
    add_row(prb_pkg::ACT_RESEEK,    2'd1, 32'd100,       4'b0110, 1, 0, 0, 1, 32'd100);
    add_row(prb_pkg::ACT_TICK,      2'd1, 32'd100,       4'b0110, 1, 1, 1, 0, 32'd0);
    add_row(prb_pkg::ACT_TICK,      2'd1, 32'd200,       4'b0110, 1, 0, 1, 0, 32'd0);
    add_row(prb_pkg::ACT_RESEEK,    2'd2, 32'd5,         4'b1111, 1, 0, 0, 0, 32'd0);
    add_row(prb_pkg::ACT_LINK_LOST, 2'd2, 32'hFFFF_EC78, 4'b1110, 1, 0, 0, 1, 32'd0);
    add_row(prb_pkg::ACT_TICK,      2'd2, 32'd12345,     4'b1110, 1, 1, 1, 1, 32'd27345);
    add_row(prb_pkg::ACT_LINK_LOST, 2'd2, 32'd40000,     4'b1110, 1, 0, 1, 1, 32'd27345);
    add_row(prb_pkg::ACT_TICK,      2'd2, 32'd40000,     4'b1111, 1, 0, 0, 0, 32'd0);
    add_row(prb_pkg::ACT_LINK_LOST, 2'd3, 32'd0,         4'b0110, 1, 0, 0, 0, 32'd0);
    add_row(prb_pkg::ACT_LINK_LOST, 2'd3, 32'd0,         4'b1010, 1, 0, 0, 0, 32'd0);
    add_row(prb_pkg::ACT_RESEEK,    2'd3, 32'h8000_0000, 4'b1110, 1, 0, 0, 1, 32'h8000_0000);
    add_row(prb_pkg::ACT_TICK,      2'd3, 32'h8000_0000, 4'b1010, 1, 0, 0, 0, 32'h8000_0000);
    add_row(prb_pkg::ACT_RESEEK,    2'd3, 32'h7FFF_FFFF, 4'b1110, 1, 0, 0, 1, 32'h7FFF_FFFF);
    add_row(prb_pkg::ACT_TICK,      2'd3, 32'hFFFF_FFFE, 4'b1110, 0, 0, 0, 0, 32'd0);
    add_row(prb_pkg::ACT_TICK,      2'd3, 32'hFFFF_FFFF, 4'b1110, 0, 0, 0, 0, 32'd0);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (stim_table[i])
      send_item(stim_table[i].c, stim_table[i].has_exp, stim_table[i].exp,
                $urandom_range(0, 8));

    clock_ms = $urandom;
    no_gaps  = 1'b0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 40 == 0) no_gaps = $urandom_range(0, 2) == 0;
      send_item(random_cmd(), 1'b0, none, no_gaps ? 0 : $urandom_range(0, 8));
    end

    // drive one peer through enough due ticks to saturate its attempt count
    sat_peer = 2'($urandom_range(0, PEERS - 1));
    c.peer              = sat_peer;
    c.auto_reconnect    = 1'b1;
    c.has_saved_address = 1'b1;
    c.eligible          = 1'b1;
    c.connected         = 1'b0;
    c.now_ms            = clock_ms;
    c.action            = prb_pkg::ACT_LINK_UP;
    send_item(c, 1'b0, none, $urandom_range(0, 8));
    c.action            = prb_pkg::ACT_LINK_LOST;
    send_item(c, 1'b0, none, $urandom_range(0, 8));
    c.action            = prb_pkg::ACT_TICK;
    for (int i = 0; i < SATURATION_TICKS; i++) begin
      if (i % 40 == 0) no_gaps = $urandom_range(0, 1) == 0;
      clock_ms = clock_ms + 32'd180000;
      c.now_ms = clock_ms;
      send_item(c, 1'b0, none, no_gaps ? 0 : $urandom_range(0, 8));
    end

    @(negedge clk);
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("Covered %0d items on %0d peers: %0d connect kicks, top attempt count %0d.",
             items_accepted, PEERS, kicks_seen, top_tries);
    $display("Mismatches or stray results: %0d.", fails);
    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
